// File: sv/stable_priority_queue_unit_assert.svh
// Assertion macros shared by the priority queue modules.
// Each macro expects clk_i and rst_ni to be visible in the scope where it is used.
`ifndef STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define SPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define SPQ_ASSERT_SAME(lbl, ante, cons, msg)

`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

  // Default sizing handed to the top level parameters.
  parameter int unsigned DefCapacity     = 16;
  parameter int unsigned DefPriorityBits = 8;

  // Fixed field widths.
  localparam int unsigned DataW     = 32;
  localparam int unsigned InPrioW   = 8;
  localparam int unsigned OpW       = 2;
  localparam int unsigned StatusW   = 2;

  // Data returned by dequeue or peek on an empty queue.
  localparam logic signed [DataW-1:0] EmptyData = -32'sd1;

  typedef enum logic [OpW-1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DEQUEUE = 2'd1,
    OP_PEEK    = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming word
    logic exec;   // carry out the captured operation and load the result
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_stall;  // result register holds a word that is not being taken
  } spq_stat_t;

endpackage

`default_nettype wire

// File: sv/spq_datapath.sv
`default_nettype none

module spq_datapath #(
  parameter int unsigned CAPACITY      = spq_pkg::DefCapacity,
  parameter int unsigned PRIORITY_BITS = spq_pkg::DefPriorityBits
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire spq_pkg::spq_cmd_t              cmd_i,
  output spq_pkg::spq_stat_t                  stat_o,
  input  wire spq_pkg::op_e                   operation_i,
  input  wire logic signed [spq_pkg::DataW-1:0] item_data_i,
  input  wire logic [spq_pkg::InPrioW-1:0]    item_priority_i,
  input  wire                                 m_ready_i,
  output logic                                m_valid_o,
  output logic signed [spq_pkg::DataW-1:0]    m_data_o,
  output spq_pkg::status_e                    m_status_o
);

  `include "stable_priority_queue_unit_assert.svh"

  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  // Captured operation.
  spq_pkg::op_e                       op_q;
  logic signed [spq_pkg::DataW-1:0]   data_q;
  logic [PRIORITY_BITS-1:0]           prio_q;
  logic [PRIORITY_BITS-1:0]           prio_in;

  // Slot array, slot 0 is the head.
  logic signed [spq_pkg::DataW-1:0]   slot_data_q [CAPACITY];
  logic signed [spq_pkg::DataW-1:0]   slot_data_d [CAPACITY];
  logic [PRIORITY_BITS-1:0]           slot_prio_q [CAPACITY];
  logic [PRIORITY_BITS-1:0]           slot_prio_d [CAPACITY];
  logic [CountW-1:0]                  count_q, count_d;

  // Neighbor values for the shift paths.
  logic signed [spq_pkg::DataW-1:0]   up_data   [CAPACITY];
  logic [PRIORITY_BITS-1:0]           up_prio   [CAPACITY];
  logic signed [spq_pkg::DataW-1:0]   down_data [CAPACITY];
  logic [PRIORITY_BITS-1:0]           down_prio [CAPACITY];
  logic [CAPACITY-1:0]                keep;      // slot ranks at or above the new entry
  logic [CAPACITY-1:0]                keep_prev;

  logic                               full, empty;

  // Result register.
  logic                               out_valid_q, out_valid_d;
  logic signed [spq_pkg::DataW-1:0]   res_data_q, res_data_d;
  spq_pkg::status_e                   res_status_q, res_status_d;

  // Only the low PRIORITY_BITS of the priority field take part.
  if (PRIORITY_BITS <= spq_pkg::InPrioW) begin : g_prio_narrow
    assign prio_in = item_priority_i[PRIORITY_BITS-1:0];
  end else begin : g_prio_wide
    assign prio_in = {{(PRIORITY_BITS - spq_pkg::InPrioW){1'b0}}, item_priority_i};
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    assign keep[i] = (CountW'(i) < count_q) && (slot_prio_q[i] >= prio_q);
    if (i == 0) begin : g_head
      assign up_data[i]   = data_q;
      assign up_prio[i]   = prio_q;
      assign keep_prev[i] = 1'b1;
    end else begin : g_body
      assign up_data[i]   = slot_data_q[i-1];
      assign up_prio[i]   = slot_prio_q[i-1];
      assign keep_prev[i] = keep[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign down_data[i] = slot_data_q[i];
      assign down_prio[i] = slot_prio_q[i];
    end else begin : g_inner
      assign down_data[i] = slot_data_q[i+1];
      assign down_prio[i] = slot_prio_q[i+1];
    end
  end

  assign full  = (count_q == CountW'(CAPACITY));
  assign empty = (count_q == '0);

  always_comb begin
    count_d      = count_q;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_data_d[i] = slot_data_q[i];
      slot_prio_d[i] = slot_prio_q[i];
    end
    if (cmd_i.exec) begin
      res_data_d   = '0;
      res_status_d = spq_pkg::ST_OK;
      case (op_q) inside
        spq_pkg::OP_ENQUEUE: begin
          if (full) begin
            res_status_d = spq_pkg::ST_FULL;
          end else begin
            // Entries ranking at or above the new one stay, the first slot
            // after them takes the new entry, the rest move one slot back.
            for (int i = 0; i < CAPACITY; i++) begin
              if (!keep[i]) begin
                if (keep_prev[i]) begin
                  slot_data_d[i] = data_q;
                  slot_prio_d[i] = prio_q;
                end else begin
                  slot_data_d[i] = up_data[i];
                  slot_prio_d[i] = up_prio[i];
                end
              end
            end
            count_d = count_q + CountW'(1);
          end
        end
        spq_pkg::OP_DEQUEUE, spq_pkg::OP_PEEK: begin
          if (empty) begin
            res_data_d   = spq_pkg::EmptyData;
            res_status_d = spq_pkg::ST_EMPTY;
          end else begin
            res_data_d = slot_data_q[0];
            if (op_q == spq_pkg::OP_DEQUEUE) begin
              for (int i = 0; i < CAPACITY; i++) begin
                slot_data_d[i] = down_data[i];
                slot_prio_d[i] = down_prio[i];
              end
              count_d = count_q - CountW'(1);
            end
          end
        end
        default: begin
          res_data_d   = '0;
          res_status_d = spq_pkg::ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= operation_i;
      data_q <= item_data_i;
      prio_q <= prio_in;
    end
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_data_q[i] <= slot_data_d[i];
      slot_prio_q[i] <= slot_prio_d[i];
    end
  end

  assign stat_o.out_stall = out_valid_q && !m_ready_i;
  assign m_valid_o        = out_valid_q;
  assign m_data_o         = res_data_q;
  assign m_status_o       = res_status_q;

  `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CountW'(CAPACITY),
    "entry count exceeds capacity")
  `SPQ_ASSERT_SAME(a_head_sorted, count_q >= CountW'(2), slot_prio_q[0] >= slot_prio_q[1],
    "head entry ranks below its successor")
  `SPQ_ASSERT_NEXT(a_exec_result, cmd_i.exec, out_valid_q,
    "executed operation left no result")

endmodule

`default_nettype wire

// File: sv/spq_controller.sv
`default_nettype none

module spq_controller (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire spq_pkg::spq_stat_t stat_i,
  output spq_pkg::spq_cmd_t   cmd_o
);

  `include "stable_priority_queue_unit_assert.svh"

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;

  assign in_ready_o = (state_q == StIdle);
  assign cmd_o.load = in_valid_i && in_ready_o;
  assign cmd_o.exec = (state_q == StExec) && !stat_i.out_stall;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (cmd_o.load) begin
          state_d = StExec;
        end
      end
      StExec: begin
        if (cmd_o.exec) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  `SPQ_ASSERT_NEXT(a_accept_exec, cmd_o.load, state_q == StExec,
    "accepted word did not move to execution")
  `SPQ_ASSERT_NEXT(a_stall_hold, (state_q == StExec) && stat_i.out_stall, state_q == StExec,
    "pending operation dropped while the result register was blocked")
  `SPQ_ASSERT_NEXT(a_exec_done, cmd_o.exec, in_ready_o,
    "controller not ready after executing an operation")

endmodule

`default_nettype wire

// File: sv/stable_priority_queue_unit.sv
// Stable bounded priority queue. Up to CAPACITY entries, each a 32-bit data word
// with a priority, are kept sorted by decreasing priority; entries of equal
// priority leave in arrival order. Every input word carries one operation in
// tuser (0 enqueue, 1 dequeue head, 2 peek head) and produces exactly one result
// word: dequeue and peek return the head data with status 0, or data -1 with
// status 1 on an empty queue; enqueue returns data 0 with status 0, or status 2
// when the queue is full and the entry is refused; code 3 returns data 0, status
// 0 and changes nothing. Each operation first captures the input word; then every
// slot compares its priority with the new entry and shifts in parallel, loading
// the result register. The next input word is taken as soon as the shift step
// has loaded its result, even while that result still waits on the output side,
// but no input word is taken while a captured operation waits for its shift step.
// The shift step waits only while the result register still holds an untaken
// word. Only the low PRIORITY_BITS bits of the priority field are used. The queue
// is empty after reset.
`default_nettype none

module stable_priority_queue_unit #(
  parameter int unsigned CAPACITY      = spq_pkg::DefCapacity,
  parameter int unsigned PRIORITY_BITS = spq_pkg::DefPriorityBits
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Input channel.
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [39:0] s_axis_tdata_i,   // [31:0] item_data, [39:32] item_priority
  input  wire  [1:0]  s_axis_tuser_i,   // [1:0] operation
  // Result channel.
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] result_data
  output logic [1:0]  m_axis_tuser_o    // [1:0] status
);

  spq_pkg::spq_cmd_t                     cmd;
  spq_pkg::spq_stat_t                    stat;
  logic signed [spq_pkg::DataW-1:0]      item_data;
  logic [spq_pkg::InPrioW-1:0]           item_priority;
  spq_pkg::op_e                          operation;
  logic signed [spq_pkg::DataW-1:0]      result_data;
  spq_pkg::status_e                      status;

  // Unpack the input word.
  assign item_data     = signed'(s_axis_tdata_i[31:0]);
  assign item_priority = s_axis_tdata_i[39:32];
  assign operation     = spq_pkg::op_e'(s_axis_tuser_i);

  spq_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Slot array, sorting logic and result register.
  spq_datapath #(
    .CAPACITY      (CAPACITY),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .operation_i     (operation),
    .item_data_i     (item_data),
    .item_priority_i (item_priority),
    .m_ready_i       (m_axis_tready_i),
    .m_valid_o       (m_axis_tvalid_o),
    .m_data_o        (result_data),
    .m_status_o      (status)
  );

  // Pack the result word.
  assign m_axis_tdata_o = unsigned'(result_data);
  assign m_axis_tuser_o = status;

endmodule

`default_nettype wire
